// ===== sv/ccp_pkg.sv =====
// Package for the coefficient compress packer: widths, queue entry type.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps
package ccp_pkg;

   localparam int COEFF_W         = 14;    // input coefficient, two's complement
   localparam int BYTE_W          = 8;
   localparam int CSR_W           = 2;
   localparam int MODULUS_DEF     = 3329;
   localparam int COEFF_BITS_DEF  = 12;
   localparam int POLY_LENGTH_DEF = 256;
   localparam int COEFF_BITS_MAX  = 13;
   localparam int DROP_MIN        = 2;
   localparam int KEPT_MAX        = COEFF_BITS_MAX - DROP_MIN;  // widest kept value
   localparam int KEPT_CNT_W      = $clog2(KEPT_MAX + 1);
   localparam int RES_W           = 7;     // leftover bits carried between items
   localparam int RES_CNT_W       = 3;
   localparam int ACC_W           = RES_W + KEPT_MAX;
   localparam int TOTAL_W         = $clog2(ACC_W + 1);
   localparam int WIDE_W          = 16;    // working width of the modulus add
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [CSR_W-1:0] {
      DROP_SEL_2 = 2'd0,
      DROP_SEL_6 = 2'd1,
      DROP_SEL_8 = 2'd2
   } drop_sel_type;

   typedef struct packed {
      logic [KEPT_MAX-1:0]   kept_val;   // compressed value, LSB first into stream
      logic [KEPT_CNT_W-1:0] kept_cnt;   // number of valid bits in kept_val
      logic                  poly_last;  // last coefficient of the polynomial
   } entry_type;

endpackage

// ===== sv/ccp_if.sv =====
// Channel interfaces of the packer: coefficient requests and byte responses.
// Depends on ccp_pkg for the payload widths.
`timescale 1ns / 1ps
interface ccp_req_if;
   import ccp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COEFF_W-1:0] coeff;

   modport source (output valid, output coeff, input ready);
   modport sink   (input valid, input coeff, output ready);
endinterface

interface ccp_rsp_if;
   import ccp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              poly_last;

   modport source (output valid, output out_byte, output poly_last, input ready);
   modport sink   (input valid, input out_byte, input poly_last, output ready);
endinterface

// ===== sv/ccp_front.sv =====
// Front end: accepts coefficients, reduces and compresses them, counts the polynomial.
// Depends on ccp_pkg and ccp_req_if; feeds ccp_queue.
`timescale 1ns / 1ps
module ccp_front #(
   parameter int MODULUS     = ccp_pkg::MODULUS_DEF,
   parameter int COEFF_BITS  = ccp_pkg::COEFF_BITS_DEF,
   parameter int POLY_LENGTH = ccp_pkg::POLY_LENGTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   ccp_req_if.sink                     req_chan,
   input  logic                        csr_we,
   input  logic [ccp_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        q_ready,
   output logic                        q_push,
   output ccp_pkg::entry_type          q_entry
);
   import ccp_pkg::*;

   localparam int IDX_W = $clog2(POLY_LENGTH);

   logic [CSR_W-1:0]      drop_sel_ff, drop_sel_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [KEPT_CNT_W-1:0] drop;
   logic [KEPT_CNT_W-1:0] kept;
   logic                  neg;
   logic [WIDE_W-1:0]     sum;
   logic [WIDE_W-1:0]     dec;
   logic [WIDE_W-1:0]     shifted;
   logic [KEPT_MAX-1:0]   mask;
   logic                  last;

   always_comb begin
      unique case (drop_sel_ff)
         DROP_SEL_2: drop = KEPT_CNT_W'(2);
         DROP_SEL_6: drop = KEPT_CNT_W'(6);
         default:    drop = KEPT_CNT_W'(8);
      endcase
   end

   assign kept = KEPT_CNT_W'(COEFF_BITS) - drop;
   assign neg  = req_chan.coeff[COEFF_W-1];
   // sign extend, then fold negatives up by the modulus (mod 2^16)
   assign sum  = WIDE_W'(req_chan.coeff) + (neg ? WIDE_W'(MODULUS) : '0);
   assign dec  = (sum != '0) ? sum - WIDE_W'(1) : sum;
   assign shifted = dec >> drop;
   assign mask = ~({KEPT_MAX{1'b1}} << kept);
   assign last = (idx_ff == IDX_W'(POLY_LENGTH - 1));

   assign req_chan.ready     = q_ready;
   assign q_push             = req_chan.valid && q_ready;
   assign q_entry.kept_val   = shifted[KEPT_MAX-1:0] & mask;
   assign q_entry.kept_cnt   = kept;
   assign q_entry.poly_last  = last;

   always_comb begin
      drop_sel_in = csr_we ? csr_wdata : drop_sel_ff;
      idx_in      = idx_ff;
      if (q_push) begin
         idx_in = last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_sel_ff <= '0;
         idx_ff      <= '0;
      end else begin
         drop_sel_ff <= drop_sel_in;
         idx_ff      <= idx_in;
      end
   end

endmodule

// ===== sv/ccp_queue.sv =====
// Short queue between front end and packer back end.
// Depends on ccp_pkg for the entry type and depth.
`timescale 1ns / 1ps
module ccp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ccp_pkg::entry_type push_entry,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output ccp_pkg::entry_type pop_entry
);
   import ccp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign push_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== sv/ccp_back.sv =====
// Back end: appends kept bits to the leftover bits and emits whole bytes.
// Depends on ccp_pkg and ccp_rsp_if; drains ccp_queue.
`timescale 1ns / 1ps
module ccp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  ccp_pkg::entry_type q_entry,
   output logic               q_pop,
   ccp_rsp_if.source          rsp_chan
);
   import ccp_pkg::*;

   logic [RES_W-1:0]     res_bits_ff, res_bits_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 extra_valid_ff, extra_valid_in;
   logic [BYTE_W-1:0]    extra_byte_ff, extra_byte_in;
   logic                 extra_last_ff, extra_last_in;

   logic [ACC_W-1:0]     acc;
   logic [TOTAL_W-1:0]   total;
   logic                 two_bytes;
   logic                 one_byte;
   logic                 slot_free;
   logic [ACC_W-1:0]     acc_rest;

   assign acc = ACC_W'(res_bits_ff) | (ACC_W'(q_entry.kept_val) << res_cnt_ff);
   assign total = TOTAL_W'(res_cnt_ff) + TOTAL_W'(q_entry.kept_cnt);
   assign two_bytes = (total >= TOTAL_W'(2 * BYTE_W));
   assign one_byte  = !two_bytes && (total >= TOTAL_W'(BYTE_W));
   assign acc_rest  = two_bytes ? (acc >> (2 * BYTE_W)) :
                      one_byte  ? (acc >> BYTE_W) : acc;

   // a second byte waits in the extra slot, so nothing new is taken meanwhile
   assign slot_free = !extra_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign q_pop     = q_valid && slot_free;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.poly_last = out_last_ff;

   always_comb begin
      res_bits_in    = res_bits_ff;
      res_cnt_in     = res_cnt_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_byte_in    = out_byte_ff;
      out_last_in    = out_last_ff;
      extra_valid_in = extra_valid_ff;
      extra_byte_in  = extra_byte_ff;
      extra_last_in  = extra_last_ff;

      if (q_pop) begin
         res_bits_in = acc_rest[RES_W-1:0];
         res_cnt_in  = total[RES_CNT_W-1:0];
      end

      priority if (extra_valid_ff && (!out_valid_ff || rsp_chan.ready)) begin
         out_valid_in   = 1'b1;
         out_byte_in    = extra_byte_ff;
         out_last_in    = extra_last_ff;
         extra_valid_in = 1'b0;
      end else if (q_pop && (one_byte || two_bytes)) begin
         out_valid_in   = 1'b1;
         out_byte_in    = acc[BYTE_W-1:0];
         out_last_in    = q_entry.poly_last && one_byte;
         extra_valid_in = two_bytes;
         extra_byte_in  = acc[2*BYTE_W-1:BYTE_W];
         extra_last_in  = q_entry.poly_last;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      extra_byte_ff <= extra_byte_in;
      extra_last_ff <= extra_last_in;
      if (reset) begin
         res_bits_ff    <= '0;
         res_cnt_ff     <= '0;
         out_valid_ff   <= 1'b0;
         extra_valid_ff <= 1'b0;
      end else begin
         res_bits_ff    <= res_bits_in;
         res_cnt_ff     <= res_cnt_in;
         out_valid_ff   <= out_valid_in;
         extra_valid_ff <= extra_valid_in;
      end
   end

endmodule

// ===== sv/coefficient_compress_packer_top.sv =====
// Top level of the coefficient compress packer: front end, queue, back end.
// Depends on ccp_pkg, ccp_if, ccp_front, ccp_queue and ccp_back.
//
// Usage:
//   req_chan carries one signed 14-bit coefficient per transaction (valid/ready).
//   rsp_chan carries one packed byte per transaction, with poly_last set on the
//   final byte caused by the last coefficient of a polynomial.
//   csr_we/csr_wdata write drop_select (0: drop 2, 1: drop 6, 2 or 3: drop 8);
//   write it only while the block is idle.
// Timing:
//   A coefficient is compressed in the front end and queued in the same cycle;
//   its first byte then passes the queue slot and the output byte register before
//   it is offered on rsp_chan. One coefficient per cycle is sustained while the
//   receiver keeps ready high and each yields at most one byte; a coefficient
//   yielding two bytes holds the back end until its second byte leaves the
//   extra slot, the output byte register being the limit.
//   A two-entry queue separates the front end from the back end, so when the
//   receiver stalls the front keeps accepting until the queue is full.
// Reset clears drop_select, the leftover bits and the coefficient count.
`timescale 1ns / 1ps
module coefficient_compress_packer_top #(
   parameter int MODULUS     = ccp_pkg::MODULUS_DEF,
   parameter int COEFF_BITS  = ccp_pkg::COEFF_BITS_DEF,
   parameter int POLY_LENGTH = ccp_pkg::POLY_LENGTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   ccp_req_if.sink                   req_chan,
   ccp_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [ccp_pkg::CSR_W-1:0] csr_wdata
);
   import ccp_pkg::*;

   logic      q_push;
   logic      q_ready;
   entry_type q_push_entry;
   logic      q_pop;
   logic      q_valid;
   entry_type q_pop_entry;

   ccp_front #(
      .MODULUS     (MODULUS),
      .COEFF_BITS  (COEFF_BITS),
      .POLY_LENGTH (POLY_LENGTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   ccp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_pop_entry)
   );

   ccp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_pop_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for coefficient_compress_packer_top: drives coefficients,
// predicts the packed byte stream and compares every byte with poly_last.
// Depends on ccp_pkg, ccp_if and the packer RTL.
`timescale 1ns / 1ps
module tb_top;
   import ccp_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP       = 8;
   localparam int RANDOM_ITEMS  = 870;
   localparam logic [CSR_W-1:0] DROP_SEL_8_ALT = 2'd3;   // unlisted code, behaves as 8
   localparam int EDGE_VALUES [12] = '{0, 1, -1, 2, 3328, -3328, 3329, -3329,
                                       7680, -7680, 8191, -8192};

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              poly_last;
   } packed_byte_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   ccp_req_if req_chan ();
   ccp_rsp_if rsp_chan ();

   coefficient_compress_packer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [CSR_W-1:0] pred_drop_sel = DROP_SEL_2;
   logic [RES_W-1:0] pend_bits     = '0;
   logic [2:0]       pend_cnt      = '0;
   int               poly_index    = 0;
   packed_byte_type  expected_bytes [$];

   bit burst_mode    = 1'b0;
   int error_count   = 0;
   int cycle_count   = 0;
   int coeffs_sent   = 0;
   int bytes_checked = 0;
   int poly_ends     = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                  expected_bytes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic int drop_bits(input logic [CSR_W-1:0] sel);
      unique case (sel)
         DROP_SEL_2: return 2;
         DROP_SEL_6: return 6;
         default:    return 8;
      endcase
   endfunction

   // Compress one coefficient and append the bytes it completes to the stream.
   function automatic void predict_packed_bytes(input logic signed [COEFF_W-1:0] c);
      logic [31:0]       wide;
      logic [WIDE_W-1:0] v;
      logic [31:0]       shifted;
      logic [31:0]       kept_val;
      logic [31:0]       acc;
      int                drop;
      int                kept;
      int                total;
      int                nbytes;
      bit                last;
      packed_byte_type   entry;
      wide = {{(32-COEFF_W){c[COEFF_W-1]}}, c};
      if (c[COEFF_W-1])
         wide = wide + MODULUS_DEF;
      v = wide[WIDE_W-1:0];   // below -q the sum stays negative and wraps here
      if (v != '0)
         v = v - 1'b1;
      drop     = drop_bits(pred_drop_sel);
      kept     = COEFF_BITS_DEF - drop;
      shifted  = {16'd0, v} >> drop;
      kept_val = shifted & ((32'd1 << kept) - 32'd1);
      acc      = {25'd0, pend_bits} | (kept_val << pend_cnt);
      total    = int'(pend_cnt) + kept;
      nbytes   = total / 8;
      last     = (poly_index >= POLY_LENGTH_DEF - 1);
      poly_index = last ? 0 : poly_index + 1;
      for (int i = 0; i < nbytes; i++) begin
         entry.data      = acc[8*i +: 8];
         entry.poly_last = last && (i == nbytes - 1);
         expected_bytes.push_back(entry);
      end
      pend_bits = acc[8*nbytes +: RES_W];
      pend_cnt  = 3'(total - 8*nbytes);
   endfunction

   function automatic logic signed [COEFF_W-1:0] random_coeff();
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         v = int'($urandom_range(0, 2*MODULUS_DEF));
         v = v - MODULUS_DEF;
      end else if (pick < 80) begin
         v = EDGE_VALUES[$urandom_range(0, 11)];
      end else if (pick < 90) begin
         v = int'($urandom_range(0, 16383));
      end else begin
         v = int'($urandom_range(0, 15360));
         v = v - 7680;
      end
      return v[COEFF_W-1:0];
   endfunction

   // valid stays high across back-to-back transactions; this task lowers it only for a gap
   task automatic send_coeff(input logic signed [COEFF_W-1:0] c);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.coeff <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_packed_bytes(c);
      coeffs_sent++;
   endtask

   // Hold off the sender until every byte is out, then allow for in-flight items
   // that complete no byte.
   task automatic drain_results;
      req_chan.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_drop_select(input logic [CSR_W-1:0] sel);
      csr_we    <= 1'b1;
      csr_wdata <= sel;
      @(posedge clock);
      csr_we        <= 1'b0;
      pred_drop_sel  = sel;
   endtask

   initial begin : rsp_checker
      int              stall;
      packed_byte_type want;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         bytes_checked++;
         if (rsp_chan.poly_last)
            poly_ends++;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      rsp_chan.out_byte, rsp_chan.poly_last));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_chan.out_byte, want.data));
            if (rsp_chan.poly_last !== want.poly_last)
               report_mismatch($sformatf("poly_last %0b, expected %0b (byte %02h)",
                                         rsp_chan.poly_last, want.poly_last, want.data));
         end
      end
   end

   // reset value of drop_select (drop 2), coefficient range limits and wrap cases
   task automatic test_edge_values;
      foreach (EDGE_VALUES[i])
         send_coeff(EDGE_VALUES[i][COEFF_W-1:0]);
   endtask

   task automatic test_drop_settings;
      logic [CSR_W-1:0] sels [4];
      sels = '{DROP_SEL_6, DROP_SEL_8, DROP_SEL_8_ALT, DROP_SEL_2};
      foreach (sels[i]) begin
         drain_results();
         write_drop_select(sels[i]);
         send_coeff(14'sd3328);
         send_coeff(-14'sd8192);
         send_coeff(14'sd1);
      end
   endtask

   // Steer the leftover count so the last coefficient of a polynomial completes
   // no byte. Kept widths are all even, so the leftover count is 0, 2, 4 or 6.
   task automatic test_silent_poly_end;
      logic [CSR_W-1:0] sel;
      drain_results();
      write_drop_select(DROP_SEL_8);
      while (poly_index != POLY_LENGTH_DEF - 2)
         send_coeff(random_coeff());
      drain_results();
      if (pend_cnt == 3'd0)
         sel = DROP_SEL_2;
      else if (pend_cnt == 3'd2)
         sel = DROP_SEL_6;
      else
         sel = DROP_SEL_8;
      write_drop_select(sel);
      send_coeff(random_coeff());
      drain_results();
      write_drop_select(DROP_SEL_8);
      send_coeff(random_coeff());
      // leftover bits carry into the next polynomial
      repeat (8) send_coeff(random_coeff());
   endtask

   task automatic test_random_stream;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 60 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         if (i > 0 && i % 145 == 0) begin
            drain_results();
            write_drop_select(CSR_W'($urandom_range(0, 3)));
         end
         send_coeff(random_coeff());
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.coeff <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_values();
      test_drop_settings();
      test_silent_poly_end();
      test_random_stream();
      drain_results();

      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never arrived",
                                   expected_bytes.size()));
      $display("Sent %0d coefficients over drop counts 2, 6, 8 and the alias code,",
               coeffs_sent);
      $display("checked %0d packed bytes with %0d polynomial ends, %0d mismatches.",
               bytes_checked, poly_ends, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
